// ===== hw/rtl/kse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kse_pkg
// Shared types, codes and helpers for the keyboard scancode event queue.
// ----------------------------------------------------------------------------
package kse_pkg;

  // Ring size; the ring holds QUEUE_DEPTH - 1 events at most
  localparam int QUEUE_DEPTH = 16;
  localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);

  // Command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  // Input kinds
  localparam logic KIND_SCAN = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_QUEUED   = 3'd0;
  localparam logic [2:0] ST_MODIFIER = 3'd1;
  localparam logic [2:0] ST_DROPPED  = 3'd2;
  localparam logic [2:0] ST_POPPED   = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  // Modifier scancodes (release bit stripped)
  localparam logic [6:0] SC_ALT   = 7'h38;
  localparam logic [6:0] SC_CTRL  = 7'h1D;
  localparam logic [6:0] SC_SHIFT = 7'h2A;
  localparam logic [6:0] SC_SUPER = 7'h5B;

  localparam logic [3:0] MOD_SHIFT = 4'h1;
  localparam logic [3:0] MOD_CTRL  = 4'h2;
  localparam logic [3:0] MOD_ALT   = 4'h4;
  localparam logic [3:0] MOD_SUPER = 4'h8;

  // Command opcodes
  localparam logic [1:0] OP_KEY = 2'd0;
  localparam logic [1:0] OP_MOD = 2'd1;
  localparam logic [1:0] OP_POP = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] scan_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] key_code;
    logic       key_released;
    logic [3:0] modifier_bits;
  } out_item_t;

  typedef struct packed {
    logic [1:0] op;
    logic [6:0] code;
    logic       released;
    logic [3:0] mod_mask;
  } cmd_t;

  typedef struct packed {
    logic [3:0] mods;
    logic       released;
    logic [6:0] code;
  } event_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cq_stat_t;

  typedef struct packed {
    logic ring_full;
    logic ring_empty;
    logic busy;
  } back_stat_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
  endfunction

endpackage

// ===== hw/rtl/kse_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kse_front
// Accepts items, strips the release bit and classifies each as key event,
// modifier update or pop, then pushes a command into the command queue.
// ----------------------------------------------------------------------------
module kse_front import kse_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  cq_stat_t cq_stat,
  output logic     cmd_push,
  output cmd_t     cmd_data
);

  logic [6:0] code;
  logic [3:0] mask;
  logic       seen_r;

  assign code = in_data.scan_byte[6:0];

  always_comb begin
    case (code)
      SC_ALT:   mask = MOD_ALT;
      SC_CTRL:  mask = MOD_CTRL;
      SC_SHIFT: mask = MOD_SHIFT;
      SC_SUPER: mask = MOD_SUPER;
      default:  mask = 4'h0;
    endcase
  end

  // Hold off input during reset so nothing is pushed before the queue is clear
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else begin
      seen_r <= 1'b1;
    end
  end

  assign in_ready = seen_r && !cq_stat.full;
  assign cmd_push = in_valid && in_ready;

  always_comb begin
    cmd_data.code     = code;
    cmd_data.released = in_data.scan_byte[7];
    cmd_data.mod_mask = mask;
    if (in_data.kind == KIND_POP) begin
      cmd_data.op = OP_POP;
    end else if (mask != 4'h0) begin
      cmd_data.op = OP_MOD;
    end else begin
      cmd_data.op = OP_KEY;
    end
  end

endmodule

// ===== hw/rtl/kse_cmd_q.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kse_cmd_q
// Short command queue that decouples the front classifier from the back end.
// ----------------------------------------------------------------------------
module kse_cmd_q import kse_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  cmd_t     push_data,
  input  logic     pop,
  output logic     head_valid,
  output cmd_t     head_data,
  output cq_stat_t stat
);

  cmd_t                entries_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign stat.full  = (cnt_r == CQ_CNT_W'(CQ_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_valid = !stat.empty;
  assign head_data  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + CQ_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + CQ_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CQ_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/kse_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kse_back
// Executes commands in order: modifier mask updates, event ring writes and
// ring pops, and holds the result item in the output register.
// ----------------------------------------------------------------------------
module kse_back import kse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  input  cmd_t       cmd_data,
  output logic       cmd_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  output back_stat_t stat
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  event_t            mem [QUEUE_DEPTH];
  event_t            rd_data_r;
  event_t            wr_event;
  logic              mem_we;

  logic              state_r, state_nxt;
  logic [SLOT_W-1:0] wr_slot_r, wr_slot_nxt;
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;
  logic [3:0]        mods_r, mods_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic              ring_empty, ring_full, take;

  assign ring_empty = (wr_slot_r == rd_slot_r);
  assign ring_full  = (next_slot(wr_slot_r) == rd_slot_r);
  // Take a command only when the result register is free or being emptied
  assign take       = (state_r == S_IDLE) && cmd_valid && (!out_valid_r || out_ready);
  assign cmd_pop    = take;

  assign wr_event.mods     = mods_r;
  assign wr_event.released = cmd_data.released;
  assign wr_event.code     = cmd_data.code;

  always_comb begin
    state_nxt     = state_r;
    wr_slot_nxt   = wr_slot_r;
    rd_slot_nxt   = rd_slot_r;
    mods_nxt      = mods_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;

    if (state_r == S_READ) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.status        = ST_POPPED;
      out_data_nxt.key_code      = rd_data_r.code;
      out_data_nxt.key_released  = rd_data_r.released;
      out_data_nxt.modifier_bits = rd_data_r.mods;
      state_nxt                  = S_IDLE;
    end else if (take) begin
      out_data_nxt = '0;
      case (cmd_data.op)
        OP_POP: begin
          if (ring_empty) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = ST_EMPTY;
          end else begin
            // memory read issued this edge, result formed next cycle
            rd_slot_nxt = next_slot(rd_slot_r);
            state_nxt   = S_READ;
          end
        end
        OP_MOD: begin
          mods_nxt = cmd_data.released ? (mods_r & ~cmd_data.mod_mask)
                                       : (mods_r | cmd_data.mod_mask);
          out_valid_nxt       = 1'b1;
          out_data_nxt.status = ST_MODIFIER;
        end
        OP_KEY: begin
          out_valid_nxt = 1'b1;
          if (ring_full) begin
            out_data_nxt.status = ST_DROPPED;
          end else begin
            mem_we              = 1'b1;
            wr_slot_nxt         = next_slot(wr_slot_r);
            out_data_nxt.status = ST_QUEUED;
          end
        end
        default: begin
          out_valid_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_slot_r] <= wr_event;
    end
    rd_data_r <= mem[rd_slot_r];
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_slot_r   <= '0;
      rd_slot_r   <= '0;
      mods_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_slot_r   <= wr_slot_nxt;
      rd_slot_r   <= rd_slot_nxt;
      mods_r      <= mods_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;
  assign stat.ring_full  = ring_full;
  assign stat.ring_empty = ring_empty;
  assign stat.busy       = (state_r == S_READ);

endmodule

// ===== hw/rtl/keyboard_scancode_event_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_scancode_event_queue
// Set-1 scancode modifier tracker and key event ring with pop interface.
// ----------------------------------------------------------------------------
// Each input item is a scancode byte or a pop request and gives exactly one
// result item. The front classifies the byte and pushes a command into a
// two-entry command queue; the back end executes commands in order. A pop
// that returns an event goes through the registered read port of the event
// memory before its result is formed, and no new command is taken meanwhile.
// Scancodes and empty pops sustain one item per cycle while out_ready stays
// high. The ring holds QUEUE_DEPTH - 1 events; the event memory is not
// cleared after reset, so no clearing pass delays the first item.
// ----------------------------------------------------------------------------
module keyboard_scancode_event_queue import kse_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cq_stat_t   cq_stat;
  back_stat_t bk_stat;
  logic       cmd_push, cmd_pop, head_valid;
  cmd_t       push_cmd, head_cmd;

  kse_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cq_stat  (cq_stat),
    .cmd_push (cmd_push),
    .cmd_data (push_cmd)
  );

  kse_cmd_q u_cmd_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_push),
    .push_data  (push_cmd),
    .pop        (cmd_pop),
    .head_valid (head_valid),
    .head_data  (head_cmd),
    .stat       (cq_stat)
  );

  kse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (head_valid),
    .cmd_data  (head_cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .stat      (bk_stat)
  );

`ifndef SYNTH
  a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    !(bk_stat.ring_full && bk_stat.ring_empty))
    else $error("event ring reports full and empty at once");

  a_cq_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    !(cq_stat.full && cq_stat.empty))
    else $error("command queue reports full and empty at once");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("handshake active right after reset");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_DROPPED) |-> bk_stat.ring_full)
    else $error("drop reported while ring has room");

  a_read_slot: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.busy |-> !out_valid && !cmd_pop)
    else $error("ring read overlaps a pending result");
`endif

endmodule
